### rtl/qspd_pkg.sv
// ---------------------------------------------------------------------------
// qspd_pkg : shared types and constants for the query string pair decoder
// Item layouts, sizing constants and the escape state encoding.
// ---------------------------------------------------------------------------
package qspd_pkg;

   // sizing
   localparam int MAX_PAIRS = 16;   // 1 .. 256
   localparam int MAX_LEN   = 32;   // 2 .. 256

   // pair counter holds 0 .. MAX_PAIRS, field length holds 0 .. MAX_LEN-1
   localparam int PC_W = $clog2(MAX_PAIRS + 1);
   localparam int FL_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;

   // separator characters
   localparam logic [7:0] CHAR_AMP = 8'h26;   // '&'
   localparam logic [7:0] CHAR_EQ  = 8'h3D;   // '='
   localparam logic [7:0] CHAR_PCT = 8'h25;   // '%'

   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,   // no escape pending
      ESC_PCT   = 2'd1,   // '%' seen
      ESC_DIGIT = 2'd2    // '%' and one digit seen
   } esc_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_query;
   } req_type;

   typedef struct packed {
      logic       has_char;
      logic [7:0] out_byte;
      logic [3:0] pair_index;
      logic       in_value;
      logic       field_done;
      logic       query_done;
   } rsp_type;

   typedef struct packed {
      logic [PC_W-1:0] pair_count;
      logic            value_phase;
      logic [FL_W-1:0] field_length;
      esc_type         escape_phase;
      logic [7:0]      first_digit;
   } state_type;

   typedef struct packed {
      logic       any;
      logic       has_char;
      logic [7:0] out_byte;
      logic       field_done;
      logic       in_value;
   } report_type;

   typedef struct packed {
      state_type  st;
      report_type rp;
   } step_type;

endpackage

### rtl/qspd_if.sv
// ---------------------------------------------------------------------------
// qspd_if : valid/ready channels of the query string pair decoder
// One interface for the raw byte channel, one for the result channel.
// ---------------------------------------------------------------------------
interface qspd_req_if;
   logic             valid;
   logic             ready;
   qspd_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface qspd_rsp_if;
   logic             valid;
   logic             ready;
   qspd_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/query_string_pair_decoder_core.sv
// ---------------------------------------------------------------------------
// query_string_pair_decoder_core : streaming URL query string pair decoder
// Splits a query byte stream into name/value fields with percent decoding.
// ---------------------------------------------------------------------------
// Takes one raw query byte per item (with an end-of-query flag) and gives at
// most one result item per byte: a stored character, a field end, or both,
// tagged with the pair index (low 4 bits) and a name/value flag; the last
// byte of a query always gives a result with query_done set, and all state
// then returns to its reset value for the next query. '&' opens a new pair,
// '=' closes the field and (re)starts the value, "%XY" yields one byte (hex
// digits either case, anything else counts as zero). Fields keep at most
// MAX_LEN-1 characters; after MAX_PAIRS pairs the rest of the query is
// ignored. Rate: one item per cycle while the result channel does not stall;
// the byte is held in the input register, then its result is written into
// the result register once that slot is free or drains. The rate rests on
// the per-byte decoder state (pair count, field length, escape phase), which
// is updated as an item leaves the input register for the result register.
// Bytes that give no result are consumed without occupying the result register.
// ---------------------------------------------------------------------------
module query_string_pair_decoder_core (
   input  logic       clock,
   input  logic       reset,
   qspd_req_if.sink   req_ch,
   qspd_rsp_if.source rsp_ch
);

   // ---- input register ----------------------------------------------------
   logic              in_valid_ff;
   qspd_pkg::req_type in_item_ff;
   logic              advance;

   // item moves on when the result slot is free or drains this cycle
   assign advance      = in_valid_ff && (!rsp_ch.valid || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   // ---- decoder state -----------------------------------------------------
   qspd_pkg::state_type state_ff;
   qspd_pkg::state_type state_in;

   // ---- result register ---------------------------------------------------
   logic              out_valid_ff;
   qspd_pkg::rsp_type out_item_ff;
   qspd_pkg::rsp_type out_item_in;
   logic              emit;

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_item_ff;

   // hex digit value, non-digits count as zero
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 4'(c - 8'h57);
      end else begin
         v = 4'd0;
      end
      return v;
   endfunction

   // character goes into the current field unless it is full
   function automatic qspd_pkg::step_type store_char(input qspd_pkg::step_type s,
                                                     input logic [7:0] ch);
      qspd_pkg::step_type r;
      r = s;
      if (s.st.field_length < qspd_pkg::FL_W'(qspd_pkg::MAX_LEN - 1)) begin
         r.rp.any             = 1'b1;
         r.rp.has_char        = 1'b1;
         r.rp.out_byte        = ch;
         r.rp.in_value        = s.st.value_phase;
         r.st.field_length    = s.st.field_length + 1'b1;
      end
      return r;
   endfunction

   function automatic qspd_pkg::step_type close_field(input qspd_pkg::step_type s);
      qspd_pkg::step_type r;
      r = s;
      r.rp.any        = 1'b1;
      r.rp.field_done = 1'b1;
      r.rp.in_value   = s.st.value_phase;
      return r;
   endfunction

   // one byte with no escape pending
   function automatic qspd_pkg::step_type plain_byte(input qspd_pkg::step_type s,
                                                     input logic [7:0] b,
                                                     input logic last);
      qspd_pkg::step_type r;
      r = s;
      if (b == qspd_pkg::CHAR_AMP) begin
         r = close_field(r);
         r.st.pair_count   = r.st.pair_count + 1'b1;
         r.st.value_phase  = 1'b0;
         r.st.field_length = '0;
      end else if (b == qspd_pkg::CHAR_EQ) begin
         r = close_field(r);
         r.st.value_phase  = 1'b1;
         r.st.field_length = '0;
      end else if (b == qspd_pkg::CHAR_PCT) begin
         r.st.escape_phase = last ? qspd_pkg::ESC_NONE : qspd_pkg::ESC_PCT;
      end else begin
         r = store_char(r, b);
      end
      return r;
   endfunction

   // ---- next state and result ---------------------------------------------
   always_comb begin
      qspd_pkg::step_type s;
      logic [7:0]         b;
      logic               last;
      logic               amp_closed;

      b          = in_item_ff.in_byte;
      last       = in_item_ff.end_of_query;
      amp_closed = 1'b0;
      s.st       = state_ff;
      s.rp       = '0;

      if (state_ff.pair_count >= qspd_pkg::PC_W'(qspd_pkg::MAX_PAIRS)) begin
         // pair limit reached: bytes ignored, only the end reports
         s.rp.in_value = 1'b0;
      end else begin
         unique case (state_ff.escape_phase)
            qspd_pkg::ESC_PCT: begin
               if (b == qspd_pkg::CHAR_AMP || last) begin
                  // '%' cut short: dropped, byte handled as usual
                  s.st.escape_phase = qspd_pkg::ESC_NONE;
                  s          = plain_byte(s, b, last);
                  amp_closed = (b == qspd_pkg::CHAR_AMP);
               end else begin
                  s.st.first_digit  = b;
                  s.st.escape_phase = qspd_pkg::ESC_DIGIT;
               end
            end
            qspd_pkg::ESC_DIGIT: begin
               s.st.escape_phase = qspd_pkg::ESC_NONE;
               if (b == qspd_pkg::CHAR_AMP) begin
                  // pending digit becomes a plain byte, then the '&'
                  s = plain_byte(s, state_ff.first_digit, 1'b0);
                  s.st.escape_phase = qspd_pkg::ESC_NONE;
                  s          = plain_byte(s, b, last);
                  amp_closed = 1'b1;
               end else begin
                  s = store_char(s, {hex_val(state_ff.first_digit), hex_val(b)});
               end
            end
            default: begin
               s          = plain_byte(s, b, last);
               amp_closed = (b == qspd_pkg::CHAR_AMP);
            end
         endcase
      end

      // end of query closes the open field unless '&' already did
      if (last && !amp_closed &&
          state_ff.pair_count < qspd_pkg::PC_W'(qspd_pkg::MAX_PAIRS)) begin
         s = close_field(s);
      end

      emit = s.rp.any || last;

      out_item_in.has_char   = s.rp.has_char;
      out_item_in.out_byte   = s.rp.has_char ? s.rp.out_byte : 8'h00;
      out_item_in.pair_index = 4'(state_ff.pair_count);
      out_item_in.in_value   = s.rp.in_value;
      out_item_in.field_done = s.rp.field_done;
      out_item_in.query_done = last;

      state_in = last ? '0 : s.st;
   end

   // ---- registers ---------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= emit;
            state_ff     <= state_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff <= req_ch.payload;
      end
      if (advance && emit) begin
         out_item_ff <= out_item_in;
      end
   end

endmodule

### rtl/qspd_checker.sv
// ---------------------------------------------------------------------------
// qspd_checker : port-level checks for the query string pair decoder
// Watches the result channel; attached to the core by bind.
// ---------------------------------------------------------------------------
module qspd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input qspd_pkg::rsp_type rsp_payload
);

   // a stalled result item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // no character means a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.has_char |-> rsp_payload.out_byte == 8'h00)
      else $error("out_byte set without a character");

   // an item with neither character nor field end only marks the query end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.has_char && !rsp_payload.field_done
      |-> rsp_payload.query_done)
      else $error("empty result item");

   // a query end without a field end is the pair-limit case: bare report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.query_done && !rsp_payload.field_done
      |-> !rsp_payload.has_char && !rsp_payload.in_value)
      else $error("query end left a field open");

endmodule

bind query_string_pair_decoder_core qspd_checker u_qspd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

### test/query_string_pair_decoder_core_tb.sv
// ---------------------------------------------------------------------------
// query_string_pair_decoder_core_tb : self-checking bench for the pair decoder
// Feeds query strings byte by byte through the request channel, predicts every
// result item with a local decoder model and checks it field by field.
// ---------------------------------------------------------------------------
// Flow: a short directed part covers the separators, the percent escapes and
// the ways an escape is cut short. A limits test overflows a field and the
// pair count. Then come random well-formed queries with random content,
// broken escapes and raw noise. Both channels idle at random, except for
// one long stretch with no idling. Results are matched in order against
// the predicted items.
// ---------------------------------------------------------------------------
module query_string_pair_decoder_core_tb;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 4;
   localparam int IDLE_PCT     = 34;
   localparam int RANDOM_ITEMS = 1500;
   localparam int NOISE_ITEMS  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_PRINTS   = 40;

   logic clock = 1'b0;
   logic reset;

   qspd_req_if req_bus ();
   qspd_rsp_if rsp_bus ();

   query_string_pair_decoder_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // decoder model state
   int                pair_cnt;
   logic              val_ph;
   int                fld_len;
   qspd_pkg::esc_type esc_ph;
   logic [7:0]        pend_digit;

   // what the current byte reports
   logic        rp_any;
   logic        rp_char;
   logic [7:0]  rp_byte;
   logic        rp_done;
   int          rp_pair;
   logic        rp_inval;

   qspd_pkg::rsp_type pending_results[$];
   qspd_pkg::rsp_type got_rsp;
   qspd_pkg::rsp_type want_rsp;

   bit          steady;
   int          error_count;
   int          items_sent;
   int          results_seen;
   int          queries_sent;

   // -------------------------------------------------------------------------
   // decoder model
   // -------------------------------------------------------------------------
   function automatic void clear_state();
      pair_cnt   = 0;
      val_ph     = 1'b0;
      fld_len    = 0;
      esc_ph     = qspd_pkg::ESC_NONE;
      pend_digit = 8'h00;
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'h0;
   endfunction

   // store a character unless the field already holds MAX_LEN-1
   function automatic void keep_char(input logic [7:0] c);
      if (fld_len < qspd_pkg::MAX_LEN - 1) begin
         rp_any   = 1'b1;
         rp_char  = 1'b1;
         rp_byte  = c;
         rp_pair  = pair_cnt;
         rp_inval = val_ph;
         fld_len++;
      end
   endfunction

   function automatic void close_current();
      rp_any   = 1'b1;
      rp_done  = 1'b1;
      rp_pair  = pair_cnt;
      rp_inval = val_ph;
   endfunction

   // byte with no escape pending
   function automatic void take_plain(input logic [7:0] b, input bit is_last);
      if (b == qspd_pkg::CHAR_AMP) begin
         close_current();
         pair_cnt++;
         val_ph  = 1'b0;
         fld_len = 0;
      end else if (b == qspd_pkg::CHAR_EQ) begin
         close_current();
         val_ph  = 1'b1;
         fld_len = 0;
      end else if (b == qspd_pkg::CHAR_PCT) begin
         esc_ph = is_last ? qspd_pkg::ESC_NONE : qspd_pkg::ESC_PCT;
      end else begin
         keep_char(b);
      end
   endfunction

   // returns 1 when the byte gives a result item, filled into r
   function automatic bit decode_query_byte(input logic [7:0] b, input bit is_last,
                                            output qspd_pkg::rsp_type r);
      bit amp_closed;
      amp_closed = 1'b0;
      r        = '0;
      rp_any   = 1'b0;
      rp_char  = 1'b0;
      rp_byte  = 8'h00;
      rp_done  = 1'b0;
      rp_pair  = pair_cnt;
      rp_inval = val_ph;

      if (pair_cnt >= qspd_pkg::MAX_PAIRS) begin
         // pair limit hit: everything ignored until the end
         rp_inval = 1'b0;
      end else if (esc_ph == qspd_pkg::ESC_PCT) begin
         if (b == qspd_pkg::CHAR_AMP || is_last) begin
            // escape cut short, the '%' is dropped
            esc_ph = qspd_pkg::ESC_NONE;
            take_plain(b, is_last);
            amp_closed = (b == qspd_pkg::CHAR_AMP);
         end else begin
            pend_digit = b;
            esc_ph     = qspd_pkg::ESC_DIGIT;
         end
      end else if (esc_ph == qspd_pkg::ESC_DIGIT) begin
         esc_ph = qspd_pkg::ESC_NONE;
         if (b == qspd_pkg::CHAR_AMP) begin
            // pending digit becomes a literal, then the '&'
            take_plain(pend_digit, 1'b0);
            esc_ph = qspd_pkg::ESC_NONE;
            take_plain(b, is_last);
            amp_closed = 1'b1;
         end else begin
            keep_char({hex_nibble(pend_digit), hex_nibble(b)});
         end
      end else begin
         take_plain(b, is_last);
         amp_closed = (b == qspd_pkg::CHAR_AMP);
      end

      if (is_last && pair_cnt < qspd_pkg::MAX_PAIRS && !amp_closed) close_current();

      if (!rp_any && !is_last) return 1'b0;

      r.has_char   = rp_char;
      r.out_byte   = rp_char ? rp_byte : 8'h00;
      r.pair_index = rp_pair[3:0];
      r.in_value   = rp_inval;
      r.field_done = rp_done;
      r.query_done = is_last;
      if (is_last) clear_state();
      return 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS)
         $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %h want %h",
                                   results_seen, name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got_rsp = rsp_bus.payload;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result item %h with nothing expected", got_rsp));
         end else begin
            want_rsp = pending_results.pop_front();
            check_field("has_char",   8'(got_rsp.has_char),   8'(want_rsp.has_char));
            check_field("out_byte",   got_rsp.out_byte,       want_rsp.out_byte);
            check_field("pair_index", 8'(got_rsp.pair_index), 8'(want_rsp.pair_index));
            check_field("in_value",   8'(got_rsp.in_value),   8'(want_rsp.in_value));
            check_field("field_done", 8'(got_rsp.field_done), 8'(want_rsp.field_done));
            check_field("query_done", 8'(got_rsp.query_done), 8'(want_rsp.query_done));
         end
         results_seen++;
      end
   end

   // result side back-pressure, changed at the falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   // one item on the request channel; prediction taken at the accepting edge
   task automatic send_byte(input logic [7:0] b, input bit is_last);
      qspd_pkg::rsp_type r;
      if (!steady)
         while ($urandom_range(99) < IDLE_PCT) @(negedge clock);
      req_bus.valid                = 1'b1;
      req_bus.payload.in_byte      = b;
      req_bus.payload.end_of_query = is_last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (decode_query_byte(b, is_last, r)) pending_results.push_back(r);
      items_sent++;
      if (is_last) queries_sent++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic send_query(ref logic [7:0] q[$]);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   task automatic send_text(input string s);
      logic [7:0] q[$];
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      send_query(q);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
      else c = 8'($urandom_range(8'h21, 8'h7E));
      if (c == qspd_pkg::CHAR_AMP || c == qspd_pkg::CHAR_EQ || c == qspd_pkg::CHAR_PCT)
         c = "_";
      return c;
   endfunction

   // mostly real hex digits, sometimes anything (non-hex decodes as zero)
   function automatic logic [7:0] hex_digit();
      case ($urandom_range(9))
         0, 1, 2, 3: return 8'("0" + $urandom_range(9));
         4, 5:       return 8'("A" + $urandom_range(5));
         6, 7:       return 8'("a" + $urandom_range(5));
         default:    return 8'($urandom_range(255));
      endcase
   endfunction

   // short fields mostly, now and then one around the length cap
   function automatic int field_len();
      if ($urandom_range(99) < 3) return $urandom_range(28, 40);
      return $urandom_range(6);
   endfunction

   task automatic add_field(ref logic [7:0] q[$], input int len);
      int pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            q.push_back(plain_char());
         end else if (pick < 93) begin
            q.push_back(qspd_pkg::CHAR_PCT);
            q.push_back(hex_digit());
            q.push_back(hex_digit());
         end else if (pick < 97) begin
            q.push_back(qspd_pkg::CHAR_PCT);
            q.push_back(hex_digit());
         end else begin
            q.push_back(qspd_pkg::CHAR_PCT);
         end
      end
   endtask

   task automatic random_query();
      logic [7:0] q[$];
      int npairs;
      npairs = ($urandom_range(19) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
      for (int p = 0; p < npairs; p++) begin
         if (p > 0) q.push_back(qspd_pkg::CHAR_AMP);
         add_field(q, field_len());
         if ($urandom_range(9) < 8) begin
            q.push_back(qspd_pkg::CHAR_EQ);
            add_field(q, field_len());
            if ($urandom_range(9) == 0) begin
               // restarted value
               q.push_back(qspd_pkg::CHAR_EQ);
               add_field(q, field_len());
            end
         end
      end
      // broken tails: trailing '&', dangling escape
      case ($urandom_range(9))
         0: q.push_back(qspd_pkg::CHAR_AMP);
         1: q.push_back(qspd_pkg::CHAR_PCT);
         2: begin
            q.push_back(qspd_pkg::CHAR_PCT);
            q.push_back(hex_digit());
         end
         default: ;
      endcase
      if (q.size() == 0) q.push_back("z");
      send_query(q);
   endtask

   task automatic noise_query();
      logic [7:0] q[$];
      int n;
      n = $urandom_range(1, 12);
      repeat (n) q.push_back(8'($urandom_range(255)));
      send_query(q);
   endtask

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   task automatic test_separators();
      send_text("a=b&c");
      send_text("=x=y");      // empty name, restarted value
      send_text("=");         // name and value closed by one byte
      send_text("&");         // end right on an '&'
      send_byte(8'h00, 1'b0); // byte extremes
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_escapes();
      send_text("%41%6a%g0"); // decimal digits, lower case, non-hex digits
      send_text("%&");        // '%' cut by '&'
      send_text("%4&");       // pending digit then '&'
      send_text("%");         // '%' as the last byte
      send_text("%4");        // end right after the first digit
   endtask

   task automatic test_limits();
      logic [7:0] q[$];
      repeat (35) q.push_back(plain_char());  // name over the cap
      q.push_back(qspd_pkg::CHAR_EQ);
      repeat (34) begin
         q.push_back(qspd_pkg::CHAR_PCT);
         q.push_back(hex_digit());
         q.push_back(hex_digit());
      end
      repeat (qspd_pkg::MAX_PAIRS + 1) q.push_back(qspd_pkg::CHAR_AMP);
      q.push_back("q");                       // ignored, only query_done
      send_query(q);
   endtask

   task automatic test_random_queries();
      int start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         // a long stretch with no idling on either side
         steady = (items_sent - start >= RANDOM_ITEMS / 3) &&
                  (items_sent - start <  RANDOM_ITEMS / 2);
         if ($urandom_range(9) == 0) noise_query();
         else random_query();
      end
      steady = 1'b0;
   endtask

   task automatic test_noise();
      int start;
      start = items_sent;
      while (items_sent - start < NOISE_ITEMS) noise_query();
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      steady          = 1'b0;
      error_count     = 0;
      items_sent      = 0;
      results_seen    = 0;
      queries_sent    = 0;
      clear_state();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_separators();
      test_escapes();
      test_limits();
      test_random_queries();
      test_noise();

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d queries, checked %0d result items.",
               items_sent, queries_sent, results_seen);
      $display("Covered separators, escapes, field and pair limits, noise; %0d errors.",
               error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(2 * HALF_PERIOD * 400000);
      $display("FAIL");
      $finish;
   end

endmodule
